>>> sv/pcob_pkg.sv
// ----------------------------------------------------------------------------
// pcob_pkg
// Shared constants and types for the occupancy binner.
// ----------------------------------------------------------------------------
package pcob_pkg;

	localparam int GRID_X     = 64;
	localparam int GRID_Y     = 64;
	localparam int CELL_SHIFT = 7;
	localparam int NCELLS     = GRID_X * GRID_Y;
	localparam int AW         = $clog2(NCELLS);
	localparam int XW         = $clog2(GRID_X);

	localparam logic [6:0] OCC_VALUE = 7'd100;

	localparam logic [2:0] REG_QX  = 3'd0;
	localparam logic [2:0] REG_QY  = 3'd1;
	localparam logic [2:0] REG_QZ  = 3'd2;
	localparam logic [2:0] REG_QW  = 3'd3;
	localparam logic [2:0] REG_XS  = 3'd4;
	localparam logic [2:0] REG_YS  = 3'd5;
	localparam logic [2:0] REG_ZF  = 3'd6;
	localparam logic [2:0] REG_THR = 3'd7;

	typedef struct packed {
		logic       func;
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] pz;
		logic [11:0] cidx;
	} req_t;

	typedef struct packed {
		logic        kept;
		logic [23:0] rx;
		logic [23:0] ry;
		logic [23:0] rz;
		logic [6:0]  occ;
		logic [7:0]  hits;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture request
		logic mat;    // build matrix entries
		logic mul;    // one product step
		logic sum;    // add and round
		logic bin;    // window check, memory read
		logic upd;    // memory write and result
		logic clr;    // zero the cell addressed by the request
	} cmd_t;

	typedef struct packed {
		logic func;
		logic mul_last;
	} sts_t;

endpackage

>>> sv/pcob_ctrl.sv
// ----------------------------------------------------------------------------
// pcob_ctrl
// Sequencer for one request at a time.
// ----------------------------------------------------------------------------
module pcob_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_busy,
	input  pcob_pkg::sts_t sts,
	output pcob_pkg::cmd_t cmd,
	output logic           idle
);
	import pcob_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAT  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_BIN  = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.load = (state_q == S_IDLE) && in_fire;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_MAT;
			S_MAT: begin
				cmd.mat = 1'b1;
				state_d = sts.func ? S_BIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (sts.mul_last) state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_BIN;
			end
			S_BIN: begin
				cmd.bin = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				if (!out_busy) begin
					cmd.upd = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> sv/pcob_dp.sv
// ----------------------------------------------------------------------------
// pcob_dp
// Rotation, windowing and cell count memory.
// ----------------------------------------------------------------------------
module pcob_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  pcob_pkg::cmd_t cmd,
	input  pcob_pkg::req_t req,
	input  logic [15:0]    qx,
	input  logic [15:0]    qy,
	input  logic [15:0]    qz,
	input  logic [15:0]    qw,
	input  logic [23:0]    x_start,
	input  logic [23:0]    y_start,
	input  logic [23:0]    z_floor,
	input  logic [7:0]     thr,
	output pcob_pkg::sts_t sts,
	output pcob_pkg::rsp_t rsp,
	output logic           rsp_valid
);
	import pcob_pkg::*;

	req_t req_q;

	// 9 matrix entries at scale 2^28, each fits 34 bits signed
	logic signed [33:0] m_q [9];
	logic signed [15:0] sx, sy, sz, sw;
	logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
	logic [3:0] step_q;
	logic [1:0] row_q, col_q;
	logic signed [59:0] acc_q [3];
	logic signed [23:0] r_q [3];
	logic signed [58:0] prod;
	logic signed [33:0] mop;
	logic signed [23:0] pop;

	assign sx = qx; assign sy = qy; assign sz = qz; assign sw = qw;
	// quaternion products of 16-bit signed inputs; each fits 32 bits signed
	assign pxx = sx * sx; assign pyy = sy * sy; assign pzz = sz * sz;
	assign pxy = sx * sy; assign pxz = sx * sz; assign pyz = sy * sz;
	assign pxw = sx * sw; assign pyw = sy * sw; assign pzw = sz * sw;

	localparam logic signed [33:0] ONE = 34'sd268435456;

	function automatic logic signed [33:0] tw(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic neg);
		logic signed [33:0] s;
		s = neg ? ({{2{a[31]}}, a} - {{2{b[31]}}, b}) : ({{2{a[31]}}, a} + {{2{b[31]}}, b});
		return s <<< 1;
	endfunction

	assign sts.func     = req_q.func;
	assign sts.mul_last = (step_q == 4'd8);

	always_comb begin
		mop = m_q[step_q];
		case (col_q)
			2'd0: pop = req_q.px;
			2'd1: pop = req_q.py;
			default: pop = req_q.pz;
		endcase
		prod = 59'(mop) * 59'(pop);
	end

	// round half up then saturate
	function automatic logic signed [23:0] rnd(input logic signed [59:0] a);
		logic signed [59:0] v;
		logic signed [31:0] q;
		v = a + 60'sd134217728;
		q = 32'(v >>> 28);
		if (q > 32'sd8388607) return 24'sh7FFFFF;
		if (q < -32'sd8388608) return 24'sh800000;
		return q[23:0];
	endfunction

	// window
	logic signed [25:0] dx, dy;
	logic in_win, above;
	logic [AW-1:0] waddr_q, raddr;
	logic kept_q, cnt_q;
	logic [7:0] mem [NCELLS];
	logic [7:0] rd_q;
	logic rd_ok_q;

	assign dx = 26'(r_q[0]) - 26'($signed(x_start));
	assign dy = 26'(r_q[1]) - 26'($signed(y_start));
	assign in_win = (dx >= 0) && (dx < 26'(GRID_X << CELL_SHIFT)) &&
		(dy >= 0) && (dy < 26'(GRID_Y << CELL_SHIFT));
	assign above = $signed(r_q[2]) > $signed(z_floor);
	assign raddr = req_q.func ? req_q.cidx[AW-1:0] :
		{dy[CELL_SHIFT +: (AW-XW)], dx[CELL_SHIFT +: XW]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
				r_q[i] <= '0;
			end
			step_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end
		if (cmd.mat) begin
			m_q[0] <= ONE - tw(pyy, pzz, 1'b0);
			m_q[1] <= tw(pxy, pzw, 1'b1);
			m_q[2] <= tw(pxz, pyw, 1'b0);
			m_q[3] <= tw(pxy, pzw, 1'b0);
			m_q[4] <= ONE - tw(pxx, pzz, 1'b0);
			m_q[5] <= tw(pyz, pxw, 1'b1);
			m_q[6] <= tw(pxz, pyw, 1'b1);
			m_q[7] <= tw(pyz, pxw, 1'b0);
			m_q[8] <= ONE - tw(pxx, pyy, 1'b0);
		end
		if (cmd.mul) begin
			acc_q[row_q] <= acc_q[row_q] + 60'(prod);
			step_q <= step_q + 4'd1;
			if (col_q == 2'd2) begin
				col_q <= '0;
				row_q <= row_q + 2'd1;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
		if (cmd.sum)
			for (int i = 0; i < 3; i++) r_q[i] <= rnd(acc_q[i]);
		if (cmd.bin) begin
			waddr_q <= raddr;
			rd_q    <= mem[raddr];
			kept_q  <= !req_q.func && in_win;
			cnt_q   <= !req_q.func && in_win && above;
			rd_ok_q <= req_q.func && ({1'b0, req_q.cidx} < 13'(NCELLS));
		end
		if (cmd.upd) begin
			if (cnt_q && rd_q != 8'hFF) mem[waddr_q] <= rd_q + 8'd1;
			else if (rd_ok_q) mem[waddr_q] <= '0;
		end else if (cmd.clr) begin
			mem[req.cidx[AW-1:0]] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else rsp_valid <= cmd.upd;
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			rsp.kept <= kept_q;
			rsp.rx   <= req_q.func ? '0 : r_q[0];
			rsp.ry   <= req_q.func ? '0 : r_q[1];
			rsp.rz   <= req_q.func ? '0 : r_q[2];
			rsp.hits <= rd_ok_q ? rd_q : '0;
			rsp.occ  <= (rd_ok_q && rd_q >= thr) ? OCC_VALUE : 7'd0;
		end
	end
endmodule

>>> sv/point_cloud_occupancy_binner_unit.sv
// ----------------------------------------------------------------------------
// point_cloud_occupancy_binner_unit
// Rotates points, bins them into a 2D hit grid, reads and clears cells.
//
//   channel  dir  payload
//   s_axis   in   tdata {cell_index,point_z,point_y,point_x}, tuser func
//   m_axis   out  tdata {hit_count,occupancy,rotated_z,rotated_y,rotated_x}, tuser kept
//   cfg      in   cfg_index, cfg_data
//
// A point runs its nine products through one shared multiplier; a read
// skips them. One request at a time; a stalled result holds the
// sequencer in its last step. After reset every grid cell is cleared,
// and no request is taken until that pass is done.
// ----------------------------------------------------------------------------
module point_cloud_occupancy_binner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // point_x, point_y, point_z, cell_index
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // rotated_x, rotated_y, rotated_z, occupancy, hit_count
	output logic        m_axis_tuser,  // kept
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import pcob_pkg::*;

	logic [15:0] qx_q, qy_q, qz_q, qw_q;
	logic [23:0] xs_q, ys_q, zf_q;
	logic [7:0]  thr_q;
	cmd_t cmd, cmd_dp;
	sts_t sts;
	req_t req;
	rsp_t rsp, out_q;
	logic rsp_valid, idle, vld_q, in_fire;
	logic [AW:0] clr_q;
	logic clearing;

	assign clearing = !clr_q[AW];
	assign s_axis_tready = idle && !clearing;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign req.func = s_axis_tuser;
	assign req.px   = s_axis_tdata[23:0];
	assign req.py   = s_axis_tdata[47:24];
	assign req.pz   = s_axis_tdata[71:48];
	assign req.cidx = s_axis_tdata[83:72];

	pcob_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(vld_q),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	// clearing pass zeroes one cell per cycle
	req_t dreq;
	always_comb begin
		cmd_dp = cmd;
		dreq   = req;
		if (clearing) begin
			cmd_dp     = '0;
			cmd_dp.clr = 1'b1;
			dreq       = '0;
			dreq.cidx  = 12'(clr_q[AW-1:0]);
		end
	end

	pcob_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_dp), .req(dreq),
		.qx(qx_q), .qy(qy_q), .qz(qz_q), .qw(qw_q),
		.x_start(xs_q), .y_start(ys_q), .z_floor(zf_q), .thr(thr_q),
		.sts(sts), .rsp(rsp), .rsp_valid(rsp_valid)
	);

	// clear pass: write zero directly via dedicated path
	logic [AW:0] clr_d;
	assign clr_d = clr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			vld_q <= 1'b0;
			qx_q <= '0; qy_q <= '0; qz_q <= '0; qw_q <= 16'd16384;
			xs_q <= '0; ys_q <= 24'hFF8000; zf_q <= '0; thr_q <= 8'd2;
		end else begin
			if (clearing) clr_q <= clr_d;
			if (rsp_valid) vld_q <= 1'b1;
			else if (m_axis_tready) vld_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_QX:  qx_q  <= cfg_data[15:0];
					REG_QY:  qy_q  <= cfg_data[15:0];
					REG_QZ:  qz_q  <= cfg_data[15:0];
					REG_QW:  qw_q  <= cfg_data[15:0];
					REG_XS:  xs_q  <= cfg_data;
					REG_YS:  ys_q  <= cfg_data;
					REG_ZF:  zf_q  <= cfg_data;
					REG_THR: thr_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk)
		if (rsp_valid) out_q <= rsp;

	assign m_axis_tvalid = vld_q;
	assign m_axis_tuser  = out_q.kept;
	assign m_axis_tdata  = {1'b0, out_q.hits, out_q.occ, out_q.rz, out_q.ry, out_q.rx};
endmodule

>>> tb/sv/tb_point_cloud_occupancy_binner_unit.sv
// ----------------------------------------------------------------------------
// tb_point_cloud_occupancy_binner_unit
// Drives point and cell-read requests through the binner under several
// rotation, window, floor and threshold settings. Each accepted request is
// predicted with a local rotation and hit-grid model and every result is
// checked field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_point_cloud_occupancy_binner_unit;
	import pcob_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD  = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;   // point_x, point_y, point_z, cell_index
	logic        s_axis_tuser = 1'b0; // func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;        // rotated_x, rotated_y, rotated_z, occupancy, hit_count
	logic        m_axis_tuser;        // kept
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	point_cloud_occupancy_binner_unit dut (.*);

	initial forever #5 clk = ~clk;

	// local copy of the configuration and the hit grid
	logic [15:0] q_x = 16'd0, q_y = 16'd0, q_z = 16'd0, q_w = 16'd16384;
	logic [23:0] win_x = 24'd0, win_y = 24'hFF8000, floor_z = 24'd0;
	logic [7:0]  occ_thr = 8'd2;
	logic [7:0]  cell_hits [NCELLS];

	req_t pending_q[$];
	rsp_t grid_rsp_q[$];
	int   errors = 0;
	bit   no_idle = 1'b0;
	int   pressure_req = 0;
	int   hold_left = 0;
	int   in_gap = 0;
	int   idle_cycles = 0;

	initial foreach (cell_hits[i]) cell_hits[i] = 8'd0;

	function automatic longint round_sat(longint acc);
		longint v;
		v = (acc + (64'sd1 <<< 27)) >>> 28;
		if (v > 64'sd8388607) v = 64'sd8388607;
		if (v < -64'sd8388608) v = -64'sd8388608;
		return v;
	endfunction

	function automatic rsp_t rotate_and_bin(req_t r);
		rsp_t o;
		longint qx, qy, qz, qw, px, py, pz, one;
		longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
		longint rx, ry, rz, xs, ys, zf;
		int a;
		o = '0;
		if (r.func == 1'b0) begin
			qx = $signed(q_x); qy = $signed(q_y); qz = $signed(q_z); qw = $signed(q_w);
			px = $signed(r.px); py = $signed(r.py); pz = $signed(r.pz);
			one = 64'sd1 <<< 28;
			r00 = one - 2 * (qy * qy + qz * qz);
			r01 = 2 * (qx * qy - qz * qw);
			r02 = 2 * (qx * qz + qy * qw);
			r10 = 2 * (qx * qy + qz * qw);
			r11 = one - 2 * (qx * qx + qz * qz);
			r12 = 2 * (qy * qz - qx * qw);
			r20 = 2 * (qx * qz - qy * qw);
			r21 = 2 * (qy * qz + qx * qw);
			r22 = one - 2 * (qx * qx + qy * qy);
			rx = round_sat(r00 * px + r01 * py + r02 * pz);
			ry = round_sat(r10 * px + r11 * py + r12 * pz);
			rz = round_sat(r20 * px + r21 * py + r22 * pz);
			xs = $signed(win_x); ys = $signed(win_y); zf = $signed(floor_z);
			o.kept = rx >= xs && rx < xs + (GRID_X << CELL_SHIFT) &&
				ry >= ys && ry < ys + (GRID_Y << CELL_SHIFT);
			if (o.kept && rz > zf) begin
				a = int'((rx - xs) >> CELL_SHIFT) + int'((ry - ys) >> CELL_SHIFT) * GRID_X;
				if (a < NCELLS && cell_hits[a] != 8'd255) cell_hits[a]++;
			end
			o.rx = rx[23:0]; o.ry = ry[23:0]; o.rz = rz[23:0];
		end else begin
			a = r.cidx;
			if (a < NCELLS) begin
				o.occ  = (cell_hits[a] >= occ_thr) ? OCC_VALUE : 7'd0;
				o.hits = cell_hits[a];
				cell_hits[a] = 8'd0;
			end
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				grid_rsp_q.push_back(rotate_and_bin('{func: s_axis_tuser,
					px: s_axis_tdata[23:0], py: s_axis_tdata[47:24],
					pz: s_axis_tdata[71:48], cidx: s_axis_tdata[83:72]}));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered request
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				req_t r;
				r = pending_q.pop_front();
				s_axis_tdata  <= {4'b0, r.cidx, r.pz, r.py, r.px};
				s_axis_tuser  <= r.func;
				s_axis_tvalid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				rsp_t got, exp_r;
				got = '{kept: m_axis_tuser, rx: m_axis_tdata[23:0], ry: m_axis_tdata[47:24],
					rz: m_axis_tdata[71:48], occ: m_axis_tdata[78:72],
					hits: m_axis_tdata[86:79]};
				if (grid_rsp_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					exp_r = grid_rsp_q.pop_front();
					if (got !== exp_r) begin
						errors++;
						if (errors <= 10)
							$display("mismatch kept %b/%b rx %h/%h ry %h/%h rz %h/%h occ %0d/%0d hits %0d/%0d",
								exp_r.kept, got.kept, exp_r.rx, got.rx, exp_r.ry, got.ry,
								exp_r.rz, got.rz, exp_r.occ, got.occ, exp_r.hits, got.hits);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (pressure_req > 0) begin
				pressure_req <= 0;
				hold_left <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				int p;
				p = $urandom_range(0, 99);
				if (p < 3) begin
					hold_left <= $urandom_range(8, 40);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= (p >= 30);
				end
			end
		end
	end

	// watchdog: cycles with no request, result or register write accepted
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_QX:  q_x = val[15:0];
			REG_QY:  q_y = val[15:0];
			REG_QZ:  q_z = val[15:0];
			REG_QW:  q_w = val[15:0];
			REG_XS:  win_x = val;
			REG_YS:  win_y = val;
			REG_ZF:  floor_z = val;
			default: occ_thr = val[7:0];
		endcase
	endtask

	task automatic set_config(int qx, int qy, int qz, int qw, int xs, int ys, int zf, int thr);
		write_reg(REG_QX, 24'(qx));
		write_reg(REG_QY, 24'(qy));
		write_reg(REG_QZ, 24'(qz));
		write_reg(REG_QW, 24'(qw));
		write_reg(REG_XS, 24'(xs));
		write_reg(REG_YS, 24'(ys));
		write_reg(REG_ZF, 24'(zf));
		write_reg(REG_THR, 24'(thr));
	endtask

	function automatic req_t point_req(int x, int y, int z);
		req_t r;
		r = '0;
		r.px = 24'(x); r.py = 24'(y); r.pz = 24'(z);
		return r;
	endfunction

	function automatic req_t read_req(int c);
		req_t r;
		r = '0;
		r.func = 1'b1;
		r.cidx = 12'(c);
		return r;
	endfunction

	// mostly points near the origin and reads of central cells, some wide noise
	function automatic req_t random_req();
		req_t r;
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 9) < 7)
				r = point_req($urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
					$urandom_range(0, 2000) - 1000);
			else
				r = point_req($urandom, $urandom, $urandom);
			r.cidx = 12'($urandom);
		end else begin
			if ($urandom_range(0, 9) < 7)
				r = read_req($urandom_range(24, 39) + $urandom_range(24, 39) * GRID_X);
			else
				r = read_req($urandom_range(0, NCELLS - 1));
			r.px = 24'($urandom); r.py = 24'($urandom); r.pz = 24'($urandom);
		end
		return r;
	endfunction

	task automatic push_random(int n);
		@(negedge clk);
		repeat (n) pending_q.push_back(random_req());
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() > 0 || s_axis_tvalid || grid_rsp_q.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window x 0..8191, y -32768..-24577, floor 0, threshold 2
		@(negedge clk);
		pending_q.push_back(point_req(0, -32768, 1));
		pending_q.push_back(point_req(0, -32768, 1));
		pending_q.push_back(point_req(8191, -24577, 5));
		pending_q.push_back(point_req(8192, -30000, 5));
		pending_q.push_back(point_req(-1, -30000, 5));
		pending_q.push_back(point_req(100, -24576, 5));
		pending_q.push_back(point_req(100, -32769, 5));
		pending_q.push_back(point_req(300, -32000, 0));
		pending_q.push_back(point_req(8388607, -8388608, 8388607));
		pending_q.push_back(point_req(-8388608, 8388607, -8388608));
		pending_q.push_back(read_req(0));
		pending_q.push_back(read_req(NCELLS - 1));
		pending_q.push_back(read_req(0));
		pending_q.push_back(read_req(2 + 6 * GRID_X));
		// saturate one cell, then read it
		repeat (260) pending_q.push_back(point_req(500, -32000, 7));
		pending_q.push_back(read_req(3 + 6 * GRID_X));
		pending_q.push_back(read_req(3 + 6 * GRID_X));
		drain();

		set_config(0, 0, 0, 16384, -4096, -4096, 0, 1);
		no_idle = 1'b1;
		push_random(150);
		drain();
		no_idle = 1'b0;

		set_config(0, 0, 11585, 11585, -4096, -4096, -200, 3);
		@(negedge clk);
		pressure_req = 1;
		push_random(150);
		drain();

		set_config(16384, 0, 0, 0, -4096, -4096, 100, 255);
		push_random(120);
		drain();

		set_config($urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
			$urandom_range(0, 6000) - 3000, 15000, -4096, -4096,
			$urandom_range(0, 400) - 200, $urandom_range(1, 8));
		push_random(150);
		drain();

		// extreme quaternion, window at the ends of the coordinate range, zero threshold
		set_config(-32768, 32767, -16384, 16384, -8388608, 8388607, -8388608, 0);
		@(negedge clk);
		pending_q.push_back(point_req(8388607, 8388607, 8388607));
		pending_q.push_back(point_req(-8388608, -8388608, -8388608));
		pending_q.push_back(read_req(0));
		push_random(100);
		drain();

		set_config(0, 0, 0, -16384, -4096, -4096, 8388607, 2);
		push_random(60);
		drain();

		set_config(0, 0, 0, 16384, -4096, -4096, -8388608, 2);
		push_random(120);
		drain();

		if (errors == 0 && grid_rsp_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
